// File: hdl/iplpm_pkg.sv
// Shared types and codes for the IPv4 longest-prefix-match route table.
`default_nettype none

package iplpm_pkg;

  // Operation codes carried in the request tuser
  typedef enum logic [2:0] {
    OP_ADD    = 3'd0,
    OP_REMOVE = 3'd1,
    OP_LOOKUP = 3'd2,
    OP_GET    = 3'd3,
    OP_FIND   = 3'd4
  } op_t;

  // Result status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_NONE = 2'd2;

  // Fixed field widths
  localparam int ADDR_W  = 32;
  localparam int IDX_W   = 5;
  localparam int IFACE_W = 8;
  localparam int PLEN_W  = 6;

  // How one scanned slot counts as a hit
  typedef enum logic [1:0] {
    MODE_FREE   = 2'd0,  // first empty slot
    MODE_VALID  = 2'd1,  // slot holds a route
    MODE_EXACT  = 2'd2,  // subnet and mask equal the key
    MODE_PREFIX = 2'd3   // key address falls in the subnet
  } mode_t;

  // Sequencer states
  typedef enum logic [2:0] {
    S_CLEAR  = 3'd0,
    S_IDLE   = 3'd1,
    S_SCAN   = 3'd2,
    S_DRAIN  = 3'd3,
    S_FINISH = 3'd4
  } state_t;

  // Verdict of the match unit on one slot
  typedef struct packed {
    logic                hit;
    logic [PLEN_W-1:0]   plen;
  } cand_t;

endpackage

`default_nettype wire

// File: hdl/iplpm_ram.sv
// Generic simple dual-port RAM with registered read.
`default_nettype none

module iplpm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: hdl/iplpm_match.sv
// Shared match unit: judges one slot against the key and registers the verdict.
`default_nettype none

module iplpm_match #(
  parameter int AW = 5,
  parameter int IW = 8
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_en,
  input  wire iplpm_pkg::mode_t     mode,
  input  wire logic [31:0]          key_addr,
  input  wire logic [31:0]          key_mask,
  input  wire logic [AW-1:0]        in_idx,
  input  wire logic                 ent_valid,
  input  wire logic [31:0]          ent_subnet,
  input  wire logic [31:0]          ent_mask,
  input  wire logic [31:0]          ent_gw,
  input  wire logic [IW-1:0]        ent_iface,
  output logic                      cand_en,
  output iplpm_pkg::cand_t          cand,
  output logic      [AW-1:0]        cand_idx,
  output logic      [31:0]          cand_subnet,
  output logic      [31:0]          cand_mask,
  output logic      [31:0]          cand_gw,
  output logic      [IW-1:0]        cand_iface
);

  // Byte-wise population count of a mask
  function automatic logic [5:0] ones_count(input logic [31:0] v);
    logic [3:0] part;
    logic [5:0] sum;
    sum = '0;
    for (int b = 0; b < 4; b++) begin
      part = '0;
      for (int k = 0; k < 8; k++) begin
        part = part + 4'(v[8*b+k]);
      end
      sum = sum + 6'(part);
    end
    return sum;
  endfunction

  logic hit;

  // Hit rule per mode
  always_comb begin
    case (mode)
      iplpm_pkg::MODE_FREE:   hit = !ent_valid;
      iplpm_pkg::MODE_VALID:  hit = ent_valid;
      iplpm_pkg::MODE_EXACT:  hit = ent_valid && (ent_subnet == key_addr)
                                    && (ent_mask == key_mask);
      iplpm_pkg::MODE_PREFIX: hit = ent_valid && ((key_addr & ent_mask) == ent_subnet);
      default:                hit = 1'b0;
    endcase
  end

  // Verdict register
  always_ff @(posedge clk) begin
    if (rst) begin
      cand_en <= 1'b0;
    end else begin
      cand_en <= in_en;
    end
  end

  always_ff @(posedge clk) begin
    cand.hit    <= hit;
    cand.plen   <= ones_count(ent_mask);
    cand_idx    <= in_idx;
    cand_subnet <= ent_subnet;
    cand_mask   <= ent_mask;
    cand_gw     <= ent_gw;
    cand_iface  <= ent_iface;
  end

endmodule

`default_nettype wire

// File: hdl/ipv4_lpm_route_table.sv
// Top level of the IPv4 longest-prefix-match route table.
//
//  channel  dir  handshake                      payload
//  s_axis   in   s_axis_tvalid / s_axis_tready  request: tdata fields, tuser operation
//  m_axis   out  m_axis_tvalid / m_axis_tready  result: tdata fields, tuser status
//
// Add, find and lookup scan every slot: the idle state takes the request, one
// slot is read per cycle, the read and match pipeline drains, and the finish
// state loads the result. Get and remove read a single slot. Unused codes skip
// the scan and go straight to the finish state.
// After reset a clearing pass over all TABLE_ENTRIES slots empties the table; no
// request is taken meanwhile. A finished request holds until the output
// register is free; a new request is taken while a result waits there.
`default_nettype none

module ipv4_lpm_route_table #(
  parameter int TABLE_ENTRIES = 32,
  parameter int IFACE_ID_BITS = 8
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // [31:0] key_address, [63:32] key_mask, [95:64] next_hop,
  // [103:96] iface_id, [108:104] entry_index, [111:109] zero
  input  wire logic [111:0] s_axis_tdata,
  // [2:0] operation
  input  wire logic [2:0]   s_axis_tuser,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // [4:0] slot, [36:5] route_subnet, [68:37] route_mask, [100:69] route_gateway,
  // [108:101] route_iface, [114:109] match_len, [119:115] zero
  output logic      [119:0] m_axis_tdata,
  // [1:0] status
  output logic      [1:0]   m_axis_tuser
);

  localparam int AW = $clog2(TABLE_ENTRIES);
  localparam int IW = IFACE_ID_BITS;
  localparam int DW = 1 + 96 + IW;
  localparam logic [AW-1:0] LAST = AW'(TABLE_ENTRIES - 1);

  // Request fields
  logic [31:0] in_addr, in_mask, in_gw;
  logic [7:0]  in_iface;
  logic [4:0]  in_idx;
  assign in_addr  = s_axis_tdata[31:0];
  assign in_mask  = s_axis_tdata[63:32];
  assign in_gw    = s_axis_tdata[95:64];
  assign in_iface = s_axis_tdata[103:96];
  assign in_idx   = s_axis_tdata[108:104];

  iplpm_pkg::state_t state, state_next;

  logic [2:0]        req_op;
  iplpm_pkg::mode_t  req_mode;
  logic [31:0]       req_addr, req_mask, req_gw;
  logic [IW-1:0]     req_iface;
  logic              req_skip;

  logic [AW-1:0]     scan_addr, scan_end;
  logic              rd_pend;
  logic [AW-1:0]     rd_idx;

  logic              found;
  logic [AW-1:0]     best_idx;
  logic [5:0]        best_len;
  logic [31:0]       best_subnet, best_mask, best_gw;
  logic [IW-1:0]     best_iface;

  logic              accept, out_free, out_load;
  logic              ram_we, ram_re;
  logic [AW-1:0]     ram_waddr;
  logic [DW-1:0]     ram_wdata, ram_rdata;

  logic              cand_en;
  iplpm_pkg::cand_t  cand;
  logic [AW-1:0]     cand_idx;
  logic [31:0]       cand_subnet, cand_mask, cand_gw;
  logic [IW-1:0]     cand_iface;

  logic [1:0]        res_status;
  logic [4:0]        res_slot;
  logic [31:0]       res_subnet, res_mask, res_gw;
  logic [7:0]        res_iface;
  logic [5:0]        res_plen;
  logic              res_write;
  logic [DW-1:0]     res_wdata;

  assign accept   = s_axis_tvalid && s_axis_tready;
  assign out_free = !m_axis_tvalid || m_axis_tready;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      iplpm_pkg::S_CLEAR:  if (scan_addr == LAST) state_next = iplpm_pkg::S_IDLE;
      iplpm_pkg::S_IDLE: begin
        if (s_axis_tvalid) begin
          state_next = iplpm_pkg::S_SCAN;
          case (s_axis_tuser)
            iplpm_pkg::OP_ADD, iplpm_pkg::OP_FIND, iplpm_pkg::OP_LOOKUP: ;
            iplpm_pkg::OP_REMOVE, iplpm_pkg::OP_GET: begin
              if (!(32'(in_idx) < TABLE_ENTRIES)) state_next = iplpm_pkg::S_FINISH;
            end
            default: state_next = iplpm_pkg::S_FINISH;
          endcase
        end
      end
      iplpm_pkg::S_SCAN:   if (scan_addr == scan_end) state_next = iplpm_pkg::S_DRAIN;
      iplpm_pkg::S_DRAIN:  if (!rd_pend && !cand_en) state_next = iplpm_pkg::S_FINISH;
      iplpm_pkg::S_FINISH: if (out_free) state_next = iplpm_pkg::S_IDLE;
      default:             state_next = iplpm_pkg::S_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    s_axis_tready = 1'b0;
    ram_re        = 1'b0;
    ram_we        = 1'b0;
    ram_waddr     = scan_addr;
    ram_wdata     = '0;
    out_load      = 1'b0;
    case (state)
      iplpm_pkg::S_CLEAR: ram_we = 1'b1;
      iplpm_pkg::S_IDLE:  s_axis_tready = 1'b1;
      iplpm_pkg::S_SCAN:  ram_re = 1'b1;
      iplpm_pkg::S_DRAIN: ;
      iplpm_pkg::S_FINISH: begin
        out_load  = out_free;
        ram_we    = out_free && res_write;
        ram_waddr = best_idx;
        ram_wdata = res_wdata;
      end
      default: ;
    endcase
  end

  // State, scan counter and read tracking
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= iplpm_pkg::S_CLEAR;
      scan_addr <= '0;
      rd_pend   <= 1'b0;
    end else begin
      state   <= state_next;
      rd_pend <= ram_re;
      if (accept) begin
        scan_addr <= (s_axis_tuser == iplpm_pkg::OP_REMOVE ||
                      s_axis_tuser == iplpm_pkg::OP_GET) ? AW'(in_idx) : '0;
      end else if (state == iplpm_pkg::S_CLEAR || state == iplpm_pkg::S_SCAN) begin
        scan_addr <= scan_addr + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_idx <= scan_addr;
  end

  // Latch the request
  always_ff @(posedge clk) begin
    if (accept) begin
      req_op    <= s_axis_tuser;
      req_addr  <= in_addr;
      req_mask  <= in_mask;
      req_gw    <= in_gw;
      req_iface <= IW'(in_iface);
      req_skip  <= (state_next == iplpm_pkg::S_FINISH);
      case (s_axis_tuser)
        iplpm_pkg::OP_ADD: begin
          req_mode <= iplpm_pkg::MODE_FREE;
          scan_end <= LAST;
        end
        iplpm_pkg::OP_FIND: begin
          req_mode <= iplpm_pkg::MODE_EXACT;
          scan_end <= LAST;
        end
        iplpm_pkg::OP_LOOKUP: begin
          req_mode <= iplpm_pkg::MODE_PREFIX;
          scan_end <= LAST;
        end
        default: begin
          req_mode <= iplpm_pkg::MODE_VALID;
          scan_end <= AW'(in_idx);
        end
      endcase
    end
  end

  // Best slot so far: first hit wins, lookup takes a strictly longer prefix
  always_ff @(posedge clk) begin
    if (rst) begin
      found <= 1'b0;
    end else if (accept) begin
      found <= 1'b0;
    end else if (cand_en && cand.hit &&
                 (!found || (req_mode == iplpm_pkg::MODE_PREFIX && cand.plen > best_len))) begin
      found <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cand_en && cand.hit &&
        (!found || (req_mode == iplpm_pkg::MODE_PREFIX && cand.plen > best_len))) begin
      best_idx    <= cand_idx;
      best_len    <= cand.plen;
      best_subnet <= cand_subnet;
      best_mask   <= cand_mask;
      best_gw     <= cand_gw;
      best_iface  <= cand_iface;
    end
  end

  // Result and table update
  always_comb begin
    res_status = iplpm_pkg::ST_NONE;
    res_slot   = '0;
    res_subnet = '0;
    res_mask   = '0;
    res_gw     = '0;
    res_iface  = '0;
    res_plen   = '0;
    res_write  = 1'b0;
    res_wdata  = {1'b0, best_subnet, best_mask, best_gw, best_iface};
    if (!req_skip) begin
      case (req_op)
        iplpm_pkg::OP_ADD: begin
          if (found) begin
            res_status = iplpm_pkg::ST_OK;
            res_slot   = 5'(best_idx);
            res_subnet = req_addr;
            res_mask   = req_mask;
            res_gw     = req_gw;
            res_iface  = 8'(req_iface);
            res_write  = 1'b1;
            res_wdata  = {1'b1, req_addr, req_mask, req_gw, req_iface};
          end else begin
            res_status = iplpm_pkg::ST_FULL;
          end
        end
        iplpm_pkg::OP_REMOVE, iplpm_pkg::OP_GET, iplpm_pkg::OP_FIND,
        iplpm_pkg::OP_LOOKUP: begin
          if (found) begin
            res_status = iplpm_pkg::ST_OK;
            res_slot   = 5'(best_idx);
            res_subnet = best_subnet;
            res_mask   = best_mask;
            res_gw     = best_gw;
            res_iface  = 8'(best_iface);
            res_plen   = (req_op == iplpm_pkg::OP_LOOKUP) ? best_len : '0;
            res_write  = (req_op == iplpm_pkg::OP_REMOVE);
          end
        end
        default: ;
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_axis_tdata <= {5'b0, res_plen, res_iface, res_gw, res_mask, res_subnet, res_slot};
      m_axis_tuser <= res_status;
    end
  end

  // Route storage: valid, subnet, mask, gateway, interface
  iplpm_ram #(
    .WIDTH (DW),
    .DEPTH (TABLE_ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (scan_addr),
    .rdata (ram_rdata)
  );

  iplpm_match #(
    .AW (AW),
    .IW (IW)
  ) u_match (
    .clk         (clk),
    .rst         (rst),
    .in_en       (rd_pend),
    .mode        (req_mode),
    .key_addr    (req_addr),
    .key_mask    (req_mask),
    .in_idx      (rd_idx),
    .ent_valid   (ram_rdata[DW-1]),
    .ent_subnet  (ram_rdata[DW-2 -: 32]),
    .ent_mask    (ram_rdata[DW-34 -: 32]),
    .ent_gw      (ram_rdata[DW-66 -: 32]),
    .ent_iface   (ram_rdata[IW-1:0]),
    .cand_en     (cand_en),
    .cand        (cand),
    .cand_idx    (cand_idx),
    .cand_subnet (cand_subnet),
    .cand_mask   (cand_mask),
    .cand_gw     (cand_gw),
    .cand_iface  (cand_iface)
  );

endmodule

`default_nettype wire
